@@ design/ofe_pkg.sv @@
// ----------------------------------------------------------------------------
// ofe_pkg: shared types and constants of the face edge extractor
// Field widths, character codes, status codes and the control groups that
// pass between the token unit and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ofe_pkg;

	// Fixed field widths.
	localparam int CHAR_W   = 8;
	localparam int VCOUNT_W = 24;
	localparam int EDGE_W   = 24;
	localparam int ACC_W    = 32;
	localparam int PROD_W   = 35;

	// Character codes that the parser looks for.
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// The magnitude saturates here.
	localparam logic [ACC_W-1:0] MAG_LIMIT = 32'h8000_0000;

	// Line status codes as carried on the output beat.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Token parsing phases.
	typedef enum logic [1:0] {
		PH_BETWEEN,
		PH_DIGITS,
		PH_SKIP
	} phase_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CLOSE,
		SQ_DECIDE,
		SQ_FETCH,
		SQ_EMIT
	} seq_state_t;

	// Kind of beat loaded into the output register.
	typedef enum logic [1:0] {
		OL_NONE,
		OL_ERROR,
		OL_EDGE,
		OL_CLOSING
	} out_load_t;

	// Commands from the sequencer to the token unit.
	typedef struct packed {
		logic take;
		logic close_eol;
		logic clear_line;
	} tok_ctrl_t;

endpackage

`default_nettype wire

@@ design/ofe_in_if.sv @@
// ----------------------------------------------------------------------------
// ofe_in_if: character channel
// One beat carries one byte of the face line with its line marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofe_in_if;
	logic                          valid;
	logic                          ready;
	logic [ofe_pkg::CHAR_W-1:0]    char_code;
	logic                          end_of_line;
	logic [ofe_pkg::VCOUNT_W-1:0]  vertex_count;

	modport source (output valid, output char_code, output end_of_line,
		output vertex_count, input ready);
	modport sink (input valid, input char_code, input end_of_line,
		input vertex_count, output ready);
endinterface

`default_nettype wire

@@ design/ofe_out_if.sv @@
// ----------------------------------------------------------------------------
// ofe_out_if: edge channel
// One beat carries one edge of the face loop or one error result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofe_out_if;
	logic                        valid;
	logic                        ready;
	logic [ofe_pkg::EDGE_W-1:0]  edge_start;
	logic [ofe_pkg::EDGE_W-1:0]  edge_end;
	logic                        edge_valid;
	ofe_pkg::status_t            status;
	logic                        last_of_line;

	modport source (output valid, output edge_start, output edge_end,
		output edge_valid, output status, output last_of_line, input ready);
	modport sink (input valid, input edge_start, input edge_end,
		input edge_valid, input status, input last_of_line, output ready);
endinterface

`default_nettype wire

@@ design/ofe_ram.sv @@
// ----------------------------------------------------------------------------
// ofe_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ofe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/ofe_token.sv @@
// ----------------------------------------------------------------------------
// ofe_token: token parser and index resolver
// Splits the line into tokens, accumulates the decimal value of each one,
// resolves it against the vertex count and writes valid indices to the store.
// ----------------------------------------------------------------------------
`default_nettype none

module ofe_token #(
	parameter int MAX_FACE_VERTS = 32,
	parameter int INDEX_BITS     = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ofe_pkg::tok_ctrl_t                    ctrl,
	input  wire logic [ofe_pkg::CHAR_W-1:0]            char_code,
	input  wire logic [ofe_pkg::VCOUNT_W-1:0]          vertex_count,
	output logic      [$clog2(MAX_FACE_VERTS+1)-1:0]   count,
	output ofe_pkg::status_t                           status,
	output logic      [INDEX_BITS-1:0]                 first,
	output logic                                       wr_en,
	output logic      [$clog2(MAX_FACE_VERTS)-1:0]     wr_addr,
	output logic      [INDEX_BITS-1:0]                 wr_data
);

	localparam int CNT_W = $clog2(MAX_FACE_VERTS+1);
	localparam int AW    = $clog2(MAX_FACE_VERTS);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_FACE_VERTS);

	logic [CNT_W-1:0]                  count_q;
	ofe_pkg::status_t                  status_q;
	ofe_pkg::phase_t                   phase_q;
	logic                              has_q;
	logic                              neg_q;
	logic [ofe_pkg::ACC_W-1:0]         acc_q;
	logic [ofe_pkg::VCOUNT_W-1:0]      vcount_q;
	logic [INDEX_BITS-1:0]             first_q;

	logic                              is_space;
	logic                              is_minus;
	logic                              is_digit;
	logic [ofe_pkg::CHAR_W-1:0]        digit_diff;
	logic [3:0]                        digit_val;
	logic [ofe_pkg::PROD_W-1:0]        prod;
	logic [ofe_pkg::ACC_W-1:0]         acc_mac;
	logic [ofe_pkg::VCOUNT_W-1:0]      vc_sel;
	logic                              range_err;
	logic [ofe_pkg::EDGE_W-1:0]        idx;
	logic [ofe_pkg::ACC_W-1:0]         idx_wide;
	logic                              close_now;
	logic                              store_ok;

	// Character classes.
	assign is_space   = (char_code == ofe_pkg::CH_SPACE);
	assign is_minus   = (char_code == ofe_pkg::CH_MINUS);
	assign is_digit   = (char_code >= ofe_pkg::CH_ZERO) && (char_code <= ofe_pkg::CH_NINE);
	assign digit_diff = char_code - ofe_pkg::CH_ZERO;
	assign digit_val  = digit_diff[3:0];

	// Multiply-accumulate by ten as two shifted adds, saturating at the limit.
	assign prod = (ofe_pkg::PROD_W'(acc_q) << 3) + (ofe_pkg::PROD_W'(acc_q) << 1)
		+ ofe_pkg::PROD_W'(digit_val);
	assign acc_mac = (prod > ofe_pkg::PROD_W'(ofe_pkg::MAG_LIMIT)) ? ofe_pkg::MAG_LIMIT
		: prod[ofe_pkg::ACC_W-1:0];

	// Resolver: a space closes with the live vertex count, end of line with the
	// count latched on the last beat. A zero value or one above the count fails.
	assign vc_sel    = ctrl.take ? vertex_count : vcount_q;
	assign range_err = (acc_q == '0) || (acc_q > ofe_pkg::ACC_W'(vc_sel));
	assign idx       = neg_q ? (vc_sel - acc_q[ofe_pkg::EDGE_W-1:0])
		: (acc_q[ofe_pkg::EDGE_W-1:0] - ofe_pkg::EDGE_W'(1));
	assign idx_wide  = ofe_pkg::ACC_W'(idx);

	// Token close and store write.
	assign close_now = (phase_q != ofe_pkg::PH_BETWEEN)
		&& ((ctrl.take && is_space) || ctrl.close_eol);
	assign store_ok  = close_now && has_q && (status_q == ofe_pkg::ST_OK)
		&& !range_err && (count_q != CNT_FULL);

	assign wr_en   = store_ok;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = idx_wide[INDEX_BITS-1:0];

	assign count  = count_q;
	assign status = status_q;
	assign first  = first_q;

	// Line and token state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ofe_pkg::ST_OK;
			phase_q  <= ofe_pkg::PH_BETWEEN;
			has_q    <= 1'b0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
		end else if (ctrl.clear_line) begin
			count_q  <= '0;
			status_q <= ofe_pkg::ST_OK;
			phase_q  <= ofe_pkg::PH_BETWEEN;
			has_q    <= 1'b0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
		end else if (close_now) begin
			if (has_q && (status_q == ofe_pkg::ST_OK)) begin
				if (range_err) begin
					status_q <= ofe_pkg::ST_RANGE;
				end else if (count_q == CNT_FULL) begin
					status_q <= ofe_pkg::ST_FULL;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			phase_q <= ofe_pkg::PH_BETWEEN;
			has_q   <= 1'b0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (ctrl.take && !is_space) begin
			case (phase_q)
				ofe_pkg::PH_BETWEEN: begin
					acc_q <= '0;
					neg_q <= 1'b0;
					if (is_minus) begin
						has_q   <= 1'b1;
						neg_q   <= 1'b1;
						phase_q <= ofe_pkg::PH_DIGITS;
					end else if (is_digit) begin
						has_q   <= 1'b1;
						acc_q   <= ofe_pkg::ACC_W'(digit_val);
						phase_q <= ofe_pkg::PH_DIGITS;
					end else begin
						has_q   <= 1'b0;
						phase_q <= ofe_pkg::PH_SKIP;
					end
				end
				ofe_pkg::PH_DIGITS: begin
					if (is_digit) begin
						acc_q <= acc_mac;
					end else begin
						phase_q <= ofe_pkg::PH_SKIP;
					end
				end
				default: begin
					phase_q <= ofe_pkg::PH_SKIP;
				end
			endcase
		end
	end

	// Vertex count of the latest beat, used when the line closes.
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			vcount_q <= vertex_count;
		end
	end

	// First index of the line, kept for the closing edge.
	always_ff @(posedge clk) begin
		if (store_ok && (count_q == '0)) begin
			first_q <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ design/ofe_seq.sv @@
// ----------------------------------------------------------------------------
// ofe_seq: line sequencer and output register
// Accepts characters, closes the line on its last beat and walks the index
// store to emit the closed edge loop, or one error beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ofe_seq #(
	parameter int MAX_FACE_VERTS = 32,
	parameter int INDEX_BITS     = 24
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_eol,
	output logic                                      in_ready,
	output ofe_pkg::tok_ctrl_t                        ctrl,
	input  wire logic [$clog2(MAX_FACE_VERTS+1)-1:0]  count,
	input  wire ofe_pkg::status_t                     status,
	input  wire logic [INDEX_BITS-1:0]                first,
	output logic                                      rd_en,
	output logic      [$clog2(MAX_FACE_VERTS)-1:0]    rd_addr,
	input  wire logic [INDEX_BITS-1:0]                rd_data,
	ofe_out_if.source                                 edges
);

	localparam int CNT_W = $clog2(MAX_FACE_VERTS+1);
	localparam int AW    = $clog2(MAX_FACE_VERTS);

	ofe_pkg::seq_state_t          state_q;
	ofe_pkg::seq_state_t          state_next;
	ofe_pkg::out_load_t           load;
	logic [CNT_W-1:0]             k_q;
	logic [INDEX_BITS-1:0]        prev_q;
	logic                         out_free;
	logic                         walk_done;
	logic                         line_err;

	logic                         valid_q;
	logic [ofe_pkg::EDGE_W-1:0]   start_q;
	logic [ofe_pkg::EDGE_W-1:0]   end_q;
	logic                         edge_valid_q;
	ofe_pkg::status_t             status_q;
	logic                         last_q;

	logic [ofe_pkg::ACC_W-1:0]    prev_wide;
	logic [ofe_pkg::ACC_W-1:0]    first_wide;
	logic [ofe_pkg::ACC_W-1:0]    rd_wide;

	assign out_free  = !valid_q || edges.ready;
	assign walk_done = (k_q == count);
	assign line_err  = (status != ofe_pkg::ST_OK);

	assign prev_wide  = ofe_pkg::ACC_W'(prev_q);
	assign first_wide = ofe_pkg::ACC_W'(first);
	assign rd_wide    = ofe_pkg::ACC_W'(rd_data);

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ofe_pkg::SQ_IDLE: begin
				if (in_valid && in_eol) begin
					state_next = ofe_pkg::SQ_CLOSE;
				end
			end
			ofe_pkg::SQ_CLOSE: begin
				state_next = ofe_pkg::SQ_DECIDE;
			end
			ofe_pkg::SQ_DECIDE: begin
				if (line_err) begin
					if (out_free) begin
						state_next = ofe_pkg::SQ_IDLE;
					end
				end else if (count == '0) begin
					state_next = ofe_pkg::SQ_IDLE;
				end else begin
					state_next = ofe_pkg::SQ_FETCH;
				end
			end
			ofe_pkg::SQ_FETCH: begin
				if (walk_done) begin
					if (out_free) begin
						state_next = ofe_pkg::SQ_IDLE;
					end
				end else begin
					state_next = ofe_pkg::SQ_EMIT;
				end
			end
			ofe_pkg::SQ_EMIT: begin
				if (out_free) begin
					state_next = ofe_pkg::SQ_FETCH;
				end
			end
			default: begin
				state_next = ofe_pkg::SQ_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready        = 1'b0;
		ctrl.take       = 1'b0;
		ctrl.close_eol  = 1'b0;
		ctrl.clear_line = 1'b0;
		rd_en           = 1'b0;
		load            = ofe_pkg::OL_NONE;
		case (state_q)
			ofe_pkg::SQ_IDLE: begin
				in_ready  = 1'b1;
				ctrl.take = in_valid;
			end
			ofe_pkg::SQ_CLOSE: begin
				ctrl.close_eol = 1'b1;
			end
			ofe_pkg::SQ_DECIDE: begin
				if (line_err) begin
					if (out_free) begin
						load            = ofe_pkg::OL_ERROR;
						ctrl.clear_line = 1'b1;
					end
				end else if (count == '0) begin
					ctrl.clear_line = 1'b1;
				end
			end
			ofe_pkg::SQ_FETCH: begin
				if (walk_done) begin
					if (out_free) begin
						load            = ofe_pkg::OL_CLOSING;
						ctrl.clear_line = 1'b1;
					end
				end else begin
					rd_en = 1'b1;
				end
			end
			ofe_pkg::SQ_EMIT: begin
				if (out_free) begin
					load = ofe_pkg::OL_EDGE;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign rd_addr = k_q[AW-1:0];

	// State register and walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofe_pkg::SQ_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ofe_pkg::SQ_DECIDE) begin
				k_q <= CNT_W'(1);
			end else if (load == ofe_pkg::OL_EDGE) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	// Previous index of the walk.
	always_ff @(posedge clk) begin
		if (state_q == ofe_pkg::SQ_DECIDE) begin
			prev_q <= first;
		end else if (load == ofe_pkg::OL_EDGE) begin
			prev_q <= rd_data;
		end
	end

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load != ofe_pkg::OL_NONE) begin
			valid_q <= 1'b1;
		end else if (edges.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output beat payload.
	always_ff @(posedge clk) begin
		case (load)
			ofe_pkg::OL_ERROR: begin
				start_q      <= '0;
				end_q        <= '0;
				edge_valid_q <= 1'b0;
				status_q     <= status;
				last_q       <= 1'b1;
			end
			ofe_pkg::OL_EDGE: begin
				start_q      <= prev_wide[ofe_pkg::EDGE_W-1:0];
				end_q        <= rd_wide[ofe_pkg::EDGE_W-1:0];
				edge_valid_q <= 1'b1;
				status_q     <= ofe_pkg::ST_OK;
				last_q       <= 1'b0;
			end
			ofe_pkg::OL_CLOSING: begin
				start_q      <= prev_wide[ofe_pkg::EDGE_W-1:0];
				end_q        <= first_wide[ofe_pkg::EDGE_W-1:0];
				edge_valid_q <= 1'b1;
				status_q     <= ofe_pkg::ST_OK;
				last_q       <= 1'b1;
			end
			default: begin
				start_q <= start_q;
			end
		endcase
	end

	assign edges.valid        = valid_q;
	assign edges.edge_start   = start_q;
	assign edges.edge_end     = end_q;
	assign edges.edge_valid   = edge_valid_q;
	assign edges.status       = status_q;
	assign edges.last_of_line = last_q;

endmodule

`default_nettype wire

@@ design/obj_face_edge_extractor.sv @@
// ----------------------------------------------------------------------------
// obj_face_edge_extractor: face line to closed edge loop
// Parses the characters of one face line into vertex indices, checks them
// against the vertex count and emits the closed loop of edges at line end.
// ----------------------------------------------------------------------------
//
//   channel  direction  beat carries
//   -------  ---------  ------------------------------------------------------
//   chars    sink       char_code, end_of_line, vertex_count
//   edges    source     edge_start, edge_end, edge_valid, status, last_of_line
//
// Mid-line, one character beat is taken every cycle.
// After the end-of-line beat, ready stays low while the sequencer closes the
// last token and decides, then fetches each of N-1 indices from the store and
// emits its edge, plus the closing edge; an error or empty line has no walk.
// The walk is paced by the store's single registered read port.
// A stalled edges channel holds the walk; no result is dropped.
// Reset is asynchronous; the index store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module obj_face_edge_extractor #(
	parameter int MAX_FACE_VERTS = 32,
	parameter int INDEX_BITS     = 24
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ofe_in_if.sink     chars,
	ofe_out_if.source  edges
);

	localparam int CNT_W = $clog2(MAX_FACE_VERTS+1);
	localparam int AW    = $clog2(MAX_FACE_VERTS);

	ofe_pkg::tok_ctrl_t     ctrl;
	logic [CNT_W-1:0]       count;
	ofe_pkg::status_t       line_status;
	logic [INDEX_BITS-1:0]  first;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [INDEX_BITS-1:0]  wr_data;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [INDEX_BITS-1:0]  rd_data;
	logic                   in_ready;

	assign chars.ready = in_ready;

	// Token parser and resolver.
	ofe_token #(
		.MAX_FACE_VERTS (MAX_FACE_VERTS),
		.INDEX_BITS     (INDEX_BITS)
	) u_token (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.char_code    (chars.char_code),
		.vertex_count (chars.vertex_count),
		.count        (count),
		.status       (line_status),
		.first        (first),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	// Index store.
	ofe_ram #(
		.WIDTH (INDEX_BITS),
		.DEPTH (MAX_FACE_VERTS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Line sequencer with the output register.
	ofe_seq #(
		.MAX_FACE_VERTS (MAX_FACE_VERTS),
		.INDEX_BITS     (INDEX_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_eol   (chars.end_of_line),
		.in_ready (in_ready),
		.ctrl     (ctrl),
		.count    (count),
		.status   (line_status),
		.first    (first),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.edges    (edges)
	);

endmodule

`default_nettype wire

@@ design/ofe_checker.sv @@
// ----------------------------------------------------------------------------
// ofe_checker: port-level checks of the face edge extractor
// Watches both channels and checks the shape of the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ofe_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_eol,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [ofe_pkg::EDGE_W-1:0]  edge_start,
	input wire logic [ofe_pkg::EDGE_W-1:0]  edge_end,
	input wire logic                        edge_valid,
	input wire logic [1:0]                  status,
	input wire logic                        last_of_line
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_start)
			&& $stable(edge_end) && $stable(status) && $stable(last_of_line))
		else $error("result beat changed while stalled");

	// An error beat is the only beat of its line and carries no edge.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !edge_valid |-> (status != ofe_pkg::ST_OK) && last_of_line
			&& (edge_start == '0) && (edge_end == '0))
		else $error("malformed error beat");

	// Edge beats always report a good status.
	a_edge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_valid |-> (status == ofe_pkg::ST_OK))
		else $error("edge beat with error status");

	// The character channel only closes right after a line-ending beat.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_eol))
		else $error("ready dropped without a line end");

endmodule

bind obj_face_edge_extractor ofe_checker u_ofe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (chars.valid),
	.in_ready     (chars.ready),
	.in_eol       (chars.end_of_line),
	.out_valid    (edges.valid),
	.out_ready    (edges.ready),
	.edge_start   (edges.edge_start),
	.edge_end     (edges.edge_end),
	.edge_valid   (edges.edge_valid),
	.status       (edges.status),
	.last_of_line (edges.last_of_line)
);

`default_nettype wire
